// File: rtl/ss_pkg.sv
// Stride scheduler package: slot table sizing, status and operation codes,
// controller states. Used by stride_scheduler, ss_checker and testbench; depends on nothing.
`timescale 1ns / 1ps

package ss_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int STRIDE_W   = 64;
   localparam int NUM_W      = 32;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int REQ_SLOT_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   localparam logic [STRIDE_W-1:0] PASS_RESET = 64'h0100_0000_0000_0000;
   localparam logic [NUM_W-1:0]    NUM_RESET  = 32'd1;

   // register index within the CSR space (8-byte registers)
   localparam logic REG_DEFAULT_PASS = 1'b0;

   typedef enum logic [STATUS_W-1:0] {
      ST_FREE     = 2'd0,
      ST_HELD     = 2'd1,
      ST_RUNNABLE = 2'd2,
      ST_RUNNING  = 2'd3
   } status_type;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_SET   = 2'd1,
      OP_SCHED = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE
   } state_type;

endpackage

// File: rtl/stride_scheduler.sv
// Stride scheduler: slot status flops, stride memory and scan controller.
// Depends on ss_pkg.
`timescale 1ns / 1ps

// Usage:
//  - Command channel: req_operation/req_slot/req_new_status are taken at a
//    clock edge with start high and busy low. busy stays high while a
//    command walks the stride memory.
//  - Result channel: exactly one result per command, shown for one cycle
//    with rsp_valid high; the receiver cannot stall it.
//  - Set_state, unused operation, full-table alloc and schedule with nothing
//    runnable answer in the cycle after acceptance; the next command may
//    follow at once. Alloc makes one read pass over the 16 strides for the
//    largest runnable stride. Schedule makes a min-search pass, then a
//    read-modify-write pass that rebases live strides at or above the min.
//  - The stride memory has a read and a separate write port; it is read one
//    entry per cycle into a register, and these passes walk it in order.
//  - The user writes default_pass over the APB port at byte address 0
//    (64 bits) only while idle; the block does not enforce it. pready is tied high.
//  - Synchronous reset marks every slot free, sets the process counter to 1
//    and default_pass to 2^56; strides are not cleared.
module stride_scheduler
   import ss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [REQ_SLOT_W-1:0] req_slot,
   input  logic [STATUS_W-1:0]   req_new_status,
   output logic                  rsp_valid,
   output logic                  rsp_ok,
   output logic [REQ_SLOT_W-1:0] rsp_granted_slot,
   output logic [NUM_W-1:0]      rsp_process_number,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   status_type              status_ff [SLOTS];
   status_type              status_in [SLOTS];
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rd_valid_ff;
   logic [SLOT_W-1:0]       rd_idx_ff;
   logic [STRIDE_W-1:0]     rd_data_ff;
   logic [STRIDE_W-1:0]     acc_ff, acc_in;
   logic [SLOT_W-1:0]       best_ff, best_in;
   logic                    found_ff, found_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [STRIDE_W-1:0]     pass_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [NUM_W-1:0]        rsp_num_ff, rsp_num_in;

   logic [STRIDE_W-1:0]     stride_mem [SLOTS];
   logic                    mem_we;
   logic [SLOT_W-1:0]       mem_waddr;
   logic [STRIDE_W-1:0]     mem_wdata;
   logic                    rd_en;
   logic [SLOT_W-1:0]       rd_addr;

   logic                    any_free;
   logic [SLOT_W-1:0]       free_idx;
   logic                    any_runnable;
   logic                    scan_done;
   logic [STRIDE_W:0]       diff;
   logic                    csr_wr;

   // ---------------- config port ----------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;
   assign prdata = (paddr[CSR_ADDR_W-1] == REG_DEFAULT_PASS) ? pass_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= PASS_RESET;
      end else if (csr_wr && paddr[CSR_ADDR_W-1] == REG_DEFAULT_PASS) begin
         pass_ff <= pwdata;
      end
   end

   // ---------------- stride memory ----------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stride_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= stride_mem[rd_addr];
   end

   // lowest free slot, any runnable slot
   always_comb begin
      any_free     = 1'b0;
      free_idx     = '0;
      any_runnable = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (status_ff[i] == ST_FREE) begin
            any_free = 1'b1;
            free_idx = SLOT_W'(i);
         end
         if (status_ff[i] == ST_RUNNABLE) begin
            any_runnable = 1'b1;
         end
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign scan_done = rd_valid_ff && (rd_idx_ff == SLOT_W'(SLOTS - 1));
   // borrow out of the subtract doubles as the stride >= min compare
   assign diff      = {1'b0, rd_data_ff} - {1'b0, acc_ff};
   assign rd_en     = (state_ff != S_IDLE) && (cnt_ff < CNT_W'(SLOTS));
   assign rd_addr   = cnt_ff[SLOT_W-1:0];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      num_in       = num_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_slot_in  = '0;
      rsp_num_in   = '0;
      mem_we       = 1'b0;
      mem_waddr    = rd_idx_ff;
      mem_wdata    = diff[STRIDE_W-1:0];

      if (rd_en) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = op_type'(req_operation);
               cnt_in   = '0;
               acc_in   = '0;
               found_in = 1'b0;
               case (op_type'(req_operation))
                  OP_ALLOC: begin
                     if (any_free) begin
                        best_in  = free_idx;
                        state_in = S_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_SET: begin
                     rsp_valid_in = 1'b1;
                     if (32'(req_slot) < 32'(SLOTS)) begin
                        status_in[SLOT_W'(req_slot)] = status_type'(req_new_status);
                        rsp_ok_in   = 1'b1;
                        rsp_slot_in = SLOT_W'(req_slot);
                     end
                  end
                  OP_SCHED: begin
                     if (any_runnable) begin
                        state_in = S_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (rd_valid_ff && status_ff[rd_idx_ff] == ST_RUNNABLE) begin
               if (op_ff == OP_ALLOC) begin
                  if (rd_data_ff > acc_ff) begin
                     acc_in = rd_data_ff;
                  end
               end else if (!found_ff || rd_data_ff < acc_ff) begin
                  acc_in   = rd_data_ff;
                  best_in  = rd_idx_ff;
                  found_in = 1'b1;
               end
            end
            if (scan_done) begin
               cnt_in = '0;
               if (op_ff == OP_ALLOC) begin
                  mem_we             = 1'b1;
                  mem_waddr          = best_ff;
                  mem_wdata          = acc_in;
                  status_in[best_ff] = ST_HELD;
                  num_in             = num_ff + NUM_W'(1);
                  rsp_valid_in       = 1'b1;
                  rsp_ok_in          = 1'b1;
                  rsp_slot_in        = best_ff;
                  rsp_num_in         = num_ff;
                  state_in           = S_IDLE;
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end

         S_UPDATE: begin
            // acc_ff holds the minimum; the winner's stride equals it, so it
            // rebases to zero and lands on default_pass
            if (rd_valid_ff) begin
               if (rd_idx_ff == best_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = pass_ff;
               end else if (status_ff[rd_idx_ff] != ST_FREE && !diff[STRIDE_W]) begin
                  mem_we = 1'b1;
               end
            end
            if (scan_done) begin
               status_in[best_ff] = ST_RUNNING;
               rsp_valid_in       = 1'b1;
               rsp_ok_in          = 1'b1;
               rsp_slot_in        = best_ff;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         num_ff       <= NUM_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            status_ff[i] <= ST_FREE;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= rd_en;
         found_ff     <= found_in;
         num_ff       <= num_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rd_idx_ff   <= rd_addr;
      acc_ff      <= acc_in;
      best_ff     <= best_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_num_ff  <= rsp_num_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_granted_slot   = REQ_SLOT_W'(rsp_slot_ff);
   assign rsp_process_number = rsp_num_ff;

endmodule

// File: test/ss_checker.sv
// Stride scheduler checker: watches the command, result and APB channels,
// predicts every result from its own copy of the slot table. Depends on ss_pkg.
`timescale 1ns / 1ps

module ss_checker
   import ss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [REQ_SLOT_W-1:0] req_slot,
   input  logic [STATUS_W-1:0]   req_new_status,
   input  logic                  rsp_valid,
   input  logic                  rsp_ok,
   input  logic [REQ_SLOT_W-1:0] rsp_granted_slot,
   input  logic [NUM_W-1:0]      rsp_process_number,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    errors,
   output int                    pending
);

   localparam logic [CSR_ADDR_W-1:0] PASS_ADDR = CSR_ADDR_W'({REG_DEFAULT_PASS, 3'b000});

   typedef struct packed {
      logic                  ok;
      logic [REQ_SLOT_W-1:0] slot;
      logic [NUM_W-1:0]      number;
   } grant_type;

   status_type          slot_state [SLOTS];
   logic [STRIDE_W-1:0] slot_pass_sum [SLOTS];
   logic [NUM_W-1:0]    next_number;
   logic [STRIDE_W-1:0] pass_value;
   grant_type           grant_queue [$];
   int                  fail_count = 0;

   assign errors = fail_count;

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Applies one command to the shadow table and returns its grant.
   function automatic grant_type advance_table(op_type op, logic [REQ_SLOT_W-1:0] slot,
                                               status_type st);
      grant_type           res;
      int                  pick;
      logic [STRIDE_W-1:0] edge_val;
      res = '0;
      pick = -1;
      edge_val = '0;
      case (op)
         OP_ALLOC: begin
            for (int i = 0; i < SLOTS; i++)
               if (pick < 0 && slot_state[i] == ST_FREE) pick = i;
            if (pick >= 0) begin
               // new slot starts at the largest runnable stride
               for (int i = 0; i < SLOTS; i++)
                  if (slot_state[i] == ST_RUNNABLE && slot_pass_sum[i] > edge_val)
                     edge_val = slot_pass_sum[i];
               res.ok = 1'b1;
               res.slot = pick[REQ_SLOT_W-1:0];
               res.number = next_number;
               next_number = next_number + NUM_W'(1);
               slot_state[pick] = ST_HELD;
               slot_pass_sum[pick] = edge_val;
            end
         end
         OP_SET: begin
            slot_state[slot] = st;
            res.ok = 1'b1;
            res.slot = slot;
         end
         OP_SCHED: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_state[i] == ST_RUNNABLE && (pick < 0 || slot_pass_sum[i] < edge_val)) begin
                  pick = i;
                  edge_val = slot_pass_sum[i];
               end
            if (pick >= 0) begin
               // rebase every live stride not below the winner's
               if (edge_val != '0)
                  for (int i = 0; i < SLOTS; i++)
                     if (slot_state[i] != ST_FREE && slot_pass_sum[i] >= edge_val)
                        slot_pass_sum[i] = slot_pass_sum[i] - edge_val;
               slot_state[pick] = ST_RUNNING;
               slot_pass_sum[pick] = slot_pass_sum[pick] + pass_value;
               res.ok = 1'b1;
               res.slot = pick[REQ_SLOT_W-1:0];
            end
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      grant_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_state[i] = ST_FREE;
         next_number = NUM_RESET;
         pass_value = PASS_RESET;
         grant_queue.delete();
      end else begin
         if (psel && penable && pready && paddr == PASS_ADDR) begin
            if (pwrite)
               pass_value = pwdata;
            else
               compare_field("prdata", pass_value, prdata);
         end
         if (rsp_valid) begin
            if (grant_queue.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual ok=%0b slot=%0d num=%0h",
                        $time, rsp_ok, rsp_granted_slot, rsp_process_number);
               fail_count++;
            end else begin
               want = grant_queue.pop_front();
               compare_field("ok", 64'(want.ok), 64'(rsp_ok));
               compare_field("granted_slot", 64'(want.slot), 64'(rsp_granted_slot));
               compare_field("process_number", 64'(want.number), 64'(rsp_process_number));
            end
         end
         if (start && !busy)
            grant_queue.push_back(advance_table(op_type'(req_operation), req_slot,
                                                status_type'(req_new_status)));
      end
      pending <= grant_queue.size();
   end

endmodule

// File: test/testbench.sv
// Stride scheduler testbench top: clock, reset, command and APB stimulus,
// verdict. Depends on ss_pkg, stride_scheduler and ss_checker.
`timescale 1ns / 1ps

module testbench
   import ss_pkg::*;
();

   localparam logic [CSR_ADDR_W-1:0] PASS_ADDR = CSR_ADDR_W'({REG_DEFAULT_PASS, 3'b000});
   localparam int PHASE_ITEMS = 270;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [OP_W-1:0]       req_operation = '0;
   logic [REQ_SLOT_W-1:0] req_slot = '0;
   logic [STATUS_W-1:0]   req_new_status = '0;
   logic                  rsp_valid;
   logic                  rsp_ok;
   logic [REQ_SLOT_W-1:0] rsp_granted_slot;
   logic [NUM_W-1:0]      rsp_process_number;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    errors;
   int                    pending;

   // which slots are live, and which have had a stride written by an alloc
   logic [SLOTS-1:0] live_mask = '0;
   logic [SLOTS-1:0] stride_known = '0;

   stride_scheduler uut (.*);

   ss_checker monitor (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one command transfer; may leave start low for a short burst afterward
   task automatic issue(input op_type op, input logic [REQ_SLOT_W-1:0] slot,
                        input status_type st, input int idle_pct);
      int pick;
      pick = -1;
      if (op == OP_ALLOC) begin
         for (int i = 0; i < SLOTS; i++)
            if (pick < 0 && !live_mask[i]) pick = i;
         if (pick >= 0) begin
            live_mask[pick] = 1'b1;
            stride_known[pick] = 1'b1;
         end
      end else if (op == OP_SET) begin
         // never bring a slot to life whose stride was never written
         if (st != ST_FREE && !stride_known[slot]) st = ST_FREE;
         live_mask[slot] = (st != ST_FREE);
      end
      req_operation <= op;
      req_slot <= slot;
      req_new_status <= st;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic random_command(input int idle_pct);
      int         pick;
      int         flavor;
      op_type     op;
      status_type st;
      pick = $urandom_range(0, 99);
      flavor = $urandom_range(0, 99);
      st = status_type'($urandom_range(0, 3));
      if (pick < 15) op = OP_ALLOC;
      else if (pick < 55) begin
         op = OP_SET;
         if (flavor < 50) st = ST_RUNNABLE;
         else if (flavor < 70) st = ST_FREE;
         else if (flavor < 85) st = ST_HELD;
         else st = ST_RUNNING;
      end else if (pick < 92) op = OP_SCHED;
      else op = OP_NONE;
      issue(op, REQ_SLOT_W'($urandom_range(0, 15)), st, idle_pct);
   endtask

   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
   endtask

   // write default_pass, then read it back for the checker
   task automatic program_pass(input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PASS_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] phase_pass [6];
      int                    idle_pct;
      phase_pass[0] = PASS_RESET;
      phase_pass[1] = '1;
      phase_pass[2] = '0;
      phase_pass[3] = 64'd1;
      phase_pass[4] = {$urandom, $urandom};
      phase_pass[5] = 64'h1000_0000_0000_0000;
      idle_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, unused op, fill to full, ties, alloc with runnable
      issue(OP_SCHED, 4'd0, ST_FREE, 0);
      issue(OP_NONE, 4'd15, ST_RUNNING, 30);
      issue(OP_SET, 4'd15, ST_FREE, 0);
      repeat (SLOTS) issue(OP_ALLOC, 4'd0, ST_FREE, 30);
      issue(OP_ALLOC, 4'd0, ST_FREE, 0);
      issue(OP_SET, 4'd3, ST_RUNNABLE, 0);
      issue(OP_SET, 4'd9, ST_RUNNABLE, 0);
      issue(OP_SCHED, 4'd0, ST_FREE, 30);
      issue(OP_SCHED, 4'd0, ST_FREE, 0);
      issue(OP_SET, 4'd3, ST_RUNNABLE, 0);
      issue(OP_SET, 4'd15, ST_FREE, 30);
      issue(OP_ALLOC, 4'd0, ST_FREE, 0);

      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            drain();
            program_pass(phase_pass[ph]);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) idle_pct = $urandom_range(0, 1) ? 0 : 40;
            if (ph == 5) idle_pct = 0;
            random_command(idle_pct);
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("stride_scheduler verification clean");
      else
         $display("stride_scheduler verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("stride_scheduler verification failed");
      $finish;
   end

endmodule
